// ===== src/bilinear_resize_q11_macros.svh =====
// Assertion macros for the resizer checker.
`ifndef BILINEAR_RESIZE_Q11_MACROS_SVH
`define BILINEAR_RESIZE_Q11_MACROS_SVH

// Check that ante at one edge leads to cons at the next edge, outside reset.
`define BRQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resizer port check failed");

// Check a condition at every edge, reset included.
`define BRQ_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("resizer port check failed");

`endif

// ===== src/brq_pkg.sv =====
package brq_pkg;

    localparam int COORD_W   = 8;
    localparam int PIX_W     = 8;
    localparam int SIZE_W    = 9;
    localparam int DEN_W     = 10;
    localparam int NUM_W     = 18;
    localparam int FRAC_BITS = 11;
    localparam int WNUM_W    = DEN_W + FRAC_BITS;
    localparam int WGT_W     = 12;
    localparam int HX_W      = 19;
    localparam int ACC_W     = 31;
    localparam int OUT_SHIFT = 22;
    localparam int CFG_IDX_W = 2;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 12'd2048;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 9'd36;
    localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 9'd160;
    localparam logic [SIZE_W-1:0] RST_DST_WIDTH  = 9'd36;
    localparam logic [SIZE_W-1:0] RST_DST_HEIGHT = 9'd80;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_PIXEL,
        KIND_BLANK
    } kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] src_height;
        logic [SIZE_W-1:0] dst_width;
        logic [SIZE_W-1:0] dst_height;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        logic               negx;
        logic               negy;
        logic [NUM_W-1:0]   numx;
        logic [NUM_W-1:0]   numy;
        logic [DEN_W-1:0]   denx;
        logic [DEN_W-1:0]   deny;
    } fe_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        logic               negx;
        logic [DEN_W-1:0]   denx;
    } dx_tag_t;

    typedef struct packed {
        logic               negy;
        logic [DEN_W-1:0]   deny;
    } dy_tag_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        logic [SIZE_W-1:0]  sx;
    } wx_tag_t;

    // Limit a programmed source size to the store's size.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int unsigned lim);
        if (int'(v) > lim)
            return SIZE_W'(lim);
        return v;
    endfunction

endpackage

// ===== src/brq_front.sv =====
module brq_front #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [brq_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [brq_pkg::SIZE_W-1:0]      cfg_wdata,
    input  logic                            req_type,
    input  logic [23:0]                     data,
    output brq_pkg::cfg_t                   cfg,
    output brq_pkg::fe_item_t               item
);
    import brq_pkg::*;

    cfg_t              cfg_reg;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              blank;
    logic [NUM_W-1:0]  prodx;
    logic [NUM_W-1:0]  prody;
    logic [NUM_W-1:0]  dx;
    logic [NUM_W-1:0]  dy;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= RST_SRC_WIDTH;
            cfg_reg.src_height <= RST_SRC_HEIGHT;
            cfg_reg.dst_width  <= RST_DST_WIDTH;
            cfg_reg.dst_height <= RST_DST_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_wdata;
                REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_wdata;
                REG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_wdata;
                REG_DST_HEIGHT: cfg_reg.dst_height <= cfg_wdata;
            endcase
        end
    end

    assign cfg = cfg_reg;
    assign col = data[7:0];
    assign row = data[15:8];

    assign w = clamp_size(cfg_reg.src_width, MAX_SRC_WIDTH);
    assign h = clamp_size(cfg_reg.src_height, MAX_SRC_HEIGHT);
    assign blank = (w < 9'd2) || (h < 9'd2) || (cfg_reg.dst_width == '0)
                   || (cfg_reg.dst_height == '0);

    // Numerator (2o+1)*in - out; a negative one is folded to its remainder.
    assign prodx = NUM_W'({col, 1'b1}) * NUM_W'(w);
    assign prody = NUM_W'({row, 1'b1}) * NUM_W'(h);
    assign dx    = NUM_W'(cfg_reg.dst_width);
    assign dy    = NUM_W'(cfg_reg.dst_height);

    always_comb
    begin
        item.col  = col;
        item.row  = row;
        item.pix  = data[23:16];
        item.negx = prodx < dx;
        item.negy = prody < dy;
        item.numx = item.negx ? prodx + dx : prodx - dx;
        item.numy = item.negy ? prody + dy : prody - dy;
        item.denx = {cfg_reg.dst_width, 1'b0};
        item.deny = {cfg_reg.dst_height, 1'b0};
        if (!req_type)
            item.kind = KIND_WRITE;
        else if (blank)
            item.kind = KIND_BLANK;
        else
            item.kind = KIND_PIXEL;
    end

endmodule

// ===== src/brq_fifo.sv =====
module brq_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  brq_pkg::fe_item_t din,
    input  logic              pop,
    output brq_pkg::fe_item_t dout,
    output logic              full,
    output logic              empty
);
    import brq_pkg::*;

    fe_item_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== src/brq_div.sv =====
module brq_div #(
    parameter int N = 18,
    parameter int M = 10,
    parameter int T = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_vld,
    input  logic [N-1:0] in_num,
    input  logic [M-1:0] in_den,
    input  logic [T-1:0] in_tag,
    output logic         out_vld,
    output logic [N-1:0] out_quo,
    output logic [M-1:0] out_rem,
    output logic [T-1:0] out_tag
);
    // One quotient bit per stage, restoring.
    logic         vld_reg [N];
    logic [M-1:0] rem_reg [N];
    logic [N-1:0] dq_reg  [N];
    logic [M-1:0] den_reg [N];
    logic [T-1:0] tag_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic         v_in;
        logic [M-1:0] r_in;
        logic [N-1:0] q_in;
        logic [M-1:0] d_in;
        logic [T-1:0] t_in;
        logic [M:0]   trial;
        logic         ge;

        if (i == 0)
        begin : g_first
            assign v_in = in_vld;
            assign r_in = '0;
            assign q_in = in_num;
            assign d_in = in_den;
            assign t_in = in_tag;
        end
        else
        begin : g_next
            assign v_in = vld_reg[i-1];
            assign r_in = rem_reg[i-1];
            assign q_in = dq_reg[i-1];
            assign d_in = den_reg[i-1];
            assign t_in = tag_reg[i-1];
        end

        assign trial = {r_in, q_in[N-1]};
        assign ge    = trial >= {1'b0, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? M'(trial - {1'b0, d_in}) : trial[M-1:0];
                dq_reg[i]  <= {q_in[N-2:0], ge};
                den_reg[i] <= d_in;
                tag_reg[i] <= t_in;
            end
        end
    end

    assign out_vld = vld_reg[N-1];
    assign out_quo = dq_reg[N-1];
    assign out_rem = rem_reg[N-1];
    assign out_tag = tag_reg[N-1];

endmodule

// ===== src/brq_back.sv =====
module brq_back #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  brq_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  brq_pkg::fe_item_t           item,
    output logic                        take,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [brq_pkg::PIX_W-1:0]   out_pixel
);
    import brq_pkg::*;

    localparam int WB     = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HB     = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int DEPTH  = WB * HB;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic en;

    // mapping dividers
    dx_tag_t            dx_in;
    dy_tag_t            dy_in;
    dx_tag_t            tx;
    dy_tag_t            ty;
    logic               vx1;
    logic               vy1;
    logic [NUM_W-1:0]   qx;
    logic [NUM_W-1:0]   qy;
    logic [DEN_W-1:0]   rx;
    logic [DEN_W-1:0]   ry;

    // weight dividers
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [SIZE_W-1:0]  sx;
    logic [SIZE_W-1:0]  sy;
    logic [DEN_W-1:0]   rxc;
    wx_tag_t            wx_in;
    wx_tag_t            t2;
    logic [SIZE_W-1:0]  sy2;
    logic               vx2;
    logic               vy2;
    logic [WNUM_W-1:0]  qx2;
    logic [WNUM_W-1:0]  qy2;
    logic [DEN_W-1:0]   rx2_unused;
    logic [DEN_W-1:0]   ry2_unused;

    // memory stage
    logic [PIX_W-1:0]   bank_q [4];
    logic               c_vld_reg;
    kind_t              c_kind_reg;
    logic [WGT_W-1:0]   c_wx0_reg;
    logic [WGT_W-1:0]   c_wy0_reg;
    logic               c_sxp_reg;
    logic               c_syp_reg;
    logic               c_vld_next;

    // blend stages
    logic [PIX_W-1:0]   p00;
    logic [PIX_W-1:0]   p01;
    logic [PIX_W-1:0]   p10;
    logic [PIX_W-1:0]   p11;
    logic [WGT_W-1:0]   wx1;
    logic               d_vld_reg;
    kind_t              d_kind_reg;
    logic [HX_W-1:0]    d_hx0_reg;
    logic [HX_W-1:0]    d_hx1_reg;
    logic [WGT_W-1:0]   d_wy0_reg;
    logic [WGT_W-1:0]   wy1;
    logic [ACC_W-1:0]   acc;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pixel_reg;

    assign en   = !out_valid_reg || out_ready;
    assign take = en;

    assign dx_in = '{kind: item.kind, col: item.col, row: item.row, pix: item.pix,
                     negx: item.negx, denx: item.denx};
    assign dy_in = '{negy: item.negy, deny: item.deny};

    brq_div #(.N(NUM_W), .M(DEN_W), .T($bits(dx_tag_t))) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(in_valid), .in_num(item.numx), .in_den(item.denx), .in_tag(dx_in),
        .out_vld(vx1), .out_quo(qx), .out_rem(rx), .out_tag(tx)
    );

    brq_div #(.N(NUM_W), .M(DEN_W), .T($bits(dy_tag_t))) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(in_valid), .in_num(item.numy), .in_den(item.deny), .in_tag(dy_in),
        .out_vld(vy1), .out_quo(qy), .out_rem(ry), .out_tag(ty)
    );

    assign w = clamp_size(cfg.src_width, MAX_SRC_WIDTH);
    assign h = clamp_size(cfg.src_height, MAX_SRC_HEIGHT);

    // Clamp the source position; columns lose their fraction at the edges.
    always_comb
    begin
        if (tx.negx)
        begin
            sx  = '0;
            rxc = '0;
        end
        else if (qx >= NUM_W'(w - 9'd1))
        begin
            sx  = w - 9'd2;
            rxc = '0;
        end
        else
        begin
            sx  = qx[SIZE_W-1:0];
            rxc = rx;
        end

        if (ty.negy)
            sy = '0;
        else if (qy > NUM_W'(h - 9'd2))
            sy = h - 9'd2;
        else
            sy = qy[SIZE_W-1:0];

        if (tx.kind == KIND_BLANK)
        begin
            sx = '0;
            sy = '0;
        end
    end

    assign wx_in = '{kind: tx.kind, col: tx.col, row: tx.row, pix: tx.pix, sx: sx};

    brq_div #(.N(WNUM_W), .M(DEN_W), .T($bits(wx_tag_t))) u_wgt_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(vx1 && vy1), .in_num({tx.denx - rxc, {FRAC_BITS{1'b0}}}),
        .in_den(tx.denx), .in_tag(wx_in),
        .out_vld(vx2), .out_quo(qx2), .out_rem(rx2_unused), .out_tag(t2)
    );

    brq_div #(.N(WNUM_W), .M(DEN_W), .T(SIZE_W)) u_wgt_y (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(vx1 && vy1), .in_num({ty.deny - ry, {FRAC_BITS{1'b0}}}),
        .in_den(ty.deny), .in_tag(sy),
        .out_vld(vy2), .out_quo(qy2), .out_rem(ry2_unused), .out_tag(sy2)
    );

    // Four banks by row and column parity; each corner lands in its own bank.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BR = 1'(b / 2);
        localparam logic BC = 1'(b % 2);

        logic [PIX_W-1:0]  ram [DEPTH];
        logic [PIX_W-1:0]  rd_reg;
        logic [SIZE_W-1:0] rrow;
        logic [SIZE_W-1:0] rcol;
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
        logic              wsel;

        assign rrow  = (sy2[0] == BR) ? sy2 : sy2 + 9'd1;
        assign rcol  = (t2.sx[0] == BC) ? t2.sx : t2.sx + 9'd1;
        assign raddr = ADDR_W'(int'(rrow >> 1) * WB + int'(rcol >> 1));
        assign waddr = ADDR_W'(int'(t2.row >> 1) * WB + int'(t2.col >> 1));
        assign wsel  = vx2 && (t2.kind == KIND_WRITE)
                       && (int'(t2.col) < MAX_SRC_WIDTH) && (int'(t2.row) < MAX_SRC_HEIGHT)
                       && (t2.row[0] == BR) && (t2.col[0] == BC);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wsel)
                    ram[waddr] <= t2.pix;
                rd_reg <= ram[raddr];
            end
        end

        assign bank_q[b] = rd_reg;
    end

    assign c_vld_next = vx2 && vy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg     <= c_vld_next;
            d_vld_reg     <= c_vld_reg;
            out_valid_reg <= d_vld_reg && (d_kind_reg != KIND_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_kind_reg <= t2.kind;
            c_wx0_reg  <= qx2[WGT_W-1:0];
            c_wy0_reg  <= qy2[WGT_W-1:0];
            c_sxp_reg  <= t2.sx[0];
            c_syp_reg  <= sy2[0];
        end
    end

    // Route bank outputs back to the four corners.
    assign p00 = c_syp_reg ? (c_sxp_reg ? bank_q[3] : bank_q[2])
                           : (c_sxp_reg ? bank_q[1] : bank_q[0]);
    assign p01 = c_syp_reg ? (c_sxp_reg ? bank_q[2] : bank_q[3])
                           : (c_sxp_reg ? bank_q[0] : bank_q[1]);
    assign p10 = c_syp_reg ? (c_sxp_reg ? bank_q[1] : bank_q[0])
                           : (c_sxp_reg ? bank_q[3] : bank_q[2]);
    assign p11 = c_syp_reg ? (c_sxp_reg ? bank_q[0] : bank_q[1])
                           : (c_sxp_reg ? bank_q[2] : bank_q[3]);
    assign wx1 = WEIGHT_ONE - c_wx0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_kind_reg <= c_kind_reg;
            d_wy0_reg  <= c_wy0_reg;
            d_hx0_reg  <= HX_W'(p00) * HX_W'(c_wx0_reg) + HX_W'(p01) * HX_W'(wx1);
            d_hx1_reg  <= HX_W'(p10) * HX_W'(c_wx0_reg) + HX_W'(p11) * HX_W'(wx1);
        end
    end

    assign wy1 = WEIGHT_ONE - d_wy0_reg;
    assign acc = ACC_W'(d_hx0_reg) * ACC_W'(d_wy0_reg)
               + ACC_W'(d_hx1_reg) * ACC_W'(wy1);

    always_ff @(posedge clk)
    begin
        if (en)
            out_pixel_reg <= (d_kind_reg == KIND_BLANK) ? '0
                                                        : acc[OUT_SHIFT +: PIX_W];
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

// ===== src/bilinear_resize_q11.sv =====
// Bilinear resizer: one item per cycle sustained, back to back, at any mix of kinds,
// while the output is not stalled. A request item shows its pixel on m_tvalid after
// the two 18-step coordinate dividers, the two 21-step weight dividers, the bank read,
// blend and output registers; a write item lands in the source store, giving no result.
// Reset (rst_n low, asynchronous) empties the queue and pipeline and loads default sizes;
// the source store is not cleared and holds nothing meaningful until written.
module bilinear_resize_q11 #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // col [7:0], row [15:8], pixel_in [23:16]
    input  logic                            s_tuser,   // req_type
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // pixel_out [7:0]
    // register writes
    input  logic                            cfg_we,
    input  logic [brq_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [brq_pkg::SIZE_W-1:0]      cfg_wdata
);
    import brq_pkg::*;

    cfg_t     cfg;
    fe_item_t fe_item;
    fe_item_t q_item;
    logic     q_full;
    logic     q_empty;
    logic     push;
    logic     take;

    // Front end: hold the size registers, classify each item and form the
    // coordinate numerators for the back end.
    brq_front #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .req_type(s_tuser), .data(s_tdata),
        .cfg(cfg), .item(fe_item)
    );

    // Accept while the queue has room; the queue absorbs output stalls.
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    brq_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .din(fe_item),
        .pop(take && !q_empty), .dout(q_item),
        .full(q_full), .empty(q_empty)
    );

    // Back end: divide, clamp, write or read four banks and blend; advance only while
    // the output register is free or being drained.
    brq_back #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg(cfg),
        .in_valid(!q_empty), .item(q_item), .take(take),
        .out_ready(m_tready), .out_valid(m_tvalid), .out_pixel(m_tdata)
    );

endmodule

// ===== src/brq_checker.sv =====
`include "bilinear_resize_q11_macros.svh"

module brq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    // Output stays offered and unchanged while stalled.
    `BRQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `BRQ_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // No result while in reset.
    `BRQ_ASSERT_ALWAYS(a_rst_quiet, !rst_n, !m_tvalid)
    // Input backpressure only follows a stalled output.
    `BRQ_ASSERT_NEXT(a_ready_cause, !(m_tvalid && !m_tready), s_tready)
endmodule

bind bilinear_resize_q11 brq_checker u_brq_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

// ===== verif/bilinear_resize_q11_checker.sv =====
`timescale 1ns / 100ps

module bilinear_resize_q11_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [23:0]                   s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,
    input  logic                          cfg_we,
    input  logic [brq_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [brq_pkg::SIZE_W-1:0]    cfg_wdata,
    output int                            fail_count,
    output int                            pending
);
    import brq_pkg::*;

    localparam int STORE_W = 256;
    localparam int STORE_H = 256;

    cfg_t             sizes;
    logic [PIX_W-1:0] image [0:STORE_W*STORE_H-1];
    logic [PIX_W-1:0] pixel_queue [$];
    int               pixel_seen;

    assign pending = pixel_queue.size();

    task automatic report(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Floor and remainder of (2o+1)*in/(2*out) - 1/2 as the rational num/den.
    function automatic void map_coord(input int o, input int src, input int dst,
                                      output longint pos, output longint rem);
        longint den;
        longint num;
        den = 2 * dst;
        num = (2 * o + 1) * src - dst;
        if (num < 0)
        begin
            pos = -1;
            rem = num + den;
        end
        else
        begin
            pos = num / den;
            rem = num % den;
        end
    endfunction

    function automatic logic [PIX_W-1:0] interpolate(input int col, input int row);
        int     w;
        int     h;
        longint sx;
        longint rx;
        longint sy;
        longint ry;
        longint wx0;
        longint wx1;
        longint wy0;
        longint wy1;
        longint acc;
        int     a00;
        w = (sizes.src_width > STORE_W) ? STORE_W : int'(sizes.src_width);
        h = (sizes.src_height > STORE_H) ? STORE_H : int'(sizes.src_height);
        if (w < 2 || h < 2 || sizes.dst_width == 0 || sizes.dst_height == 0)
            return '0;
        map_coord(col, w, sizes.dst_width, sx, rx);
        if (sx < 0)
        begin
            sx = 0;
            rx = 0;
        end
        if (sx >= w - 1)
        begin
            sx = w - 2;
            rx = 0;
        end
        wx0 = ((2 * sizes.dst_width - rx) * 2048) / (2 * sizes.dst_width);
        wx1 = 2048 - wx0;
        // rows keep their fraction even when clamped
        map_coord(row, h, sizes.dst_height, sy, ry);
        wy0 = ((2 * sizes.dst_height - ry) * 2048) / (2 * sizes.dst_height);
        wy1 = 2048 - wy0;
        if (sy > h - 2)
            sy = h - 2;
        if (sy < 0)
            sy = 0;
        a00 = int'(sy) * STORE_W + int'(sx);
        acc = image[a00] * wx0 * wy0 + image[a00 + STORE_W] * wx0 * wy1
            + image[a00 + 1] * wx1 * wy0 + image[a00 + STORE_W + 1] * wx1 * wy1;
        return PIX_W'(acc >> OUT_SHIFT);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes      <= '{RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_DST_WIDTH, RST_DST_HEIGHT};
            fail_count <= 0;
            pixel_seen <= 0;
            pixel_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SRC_WIDTH:  sizes.src_width  <= cfg_wdata;
                    REG_SRC_HEIGHT: sizes.src_height <= cfg_wdata;
                    REG_DST_WIDTH:  sizes.dst_width  <= cfg_wdata;
                    REG_DST_HEIGHT: sizes.dst_height <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    pixel_queue.push_back(interpolate(s_tdata[7:0], s_tdata[15:8]));
                else
                    image[{s_tdata[15:8], s_tdata[7:0]}] = s_tdata[23:16];
            end
            if (m_tvalid && m_tready)
            begin
                pixel_seen <= pixel_seen + 1;
                if (pixel_queue.size() == 0)
                    report("unexpected pixel_out", m_tdata, -1);
                else if (m_tdata !== pixel_queue[0])
                    report("pixel_out", m_tdata, pixel_queue[0]);
                if (pixel_queue.size() != 0)
                    void'(pixel_queue.pop_front());
            end
        end
    end

endmodule

// ===== verif/bilinear_resize_q11_test.sv =====
`timescale 1ns / 100ps

module bilinear_resize_q11_test;
    import brq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;   // past the last pixel result and write landing

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;    // col [7:0], row [15:8], pixel_in [23:16]
    logic                 s_tuser;    // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;    // pixel_out [7:0]
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [SIZE_W-1:0]    cfg_wdata;

    int                   fail_count;
    int                   pending;
    int                   cycles;
    logic                 no_gaps;      // sender runs back to back while set
    logic                 hold_request; // asks the receiver for one long hold-off
    logic                 written [0:65535];
    int                   cur_w;
    int                   cur_h;

    bilinear_resize_q11 u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    bilinear_resize_q11_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Clamped source position that output coordinate o maps to.
    function automatic int src_pos(input int o, input int src, input int dst);
        longint num;
        longint pos;
        num = longint'(2 * o + 1) * src - dst;
        pos = (num < 0) ? -1 : num / (2 * dst);
        if (pos < 0)
            pos = 0;
        if (pos > src - 2)
            pos = src - 2;
        return int'(pos);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request so the block backs up.
    int hold_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_request)
        begin
            m_tready  <= 1'b0;
            hold_left <= 300;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (no_gaps)
            m_tready <= 1'b1;
        else
        begin
            m_tready  <= (pick_gap() == 0);
            if ($urandom_range(0, 99) < 3)
                hold_left <= $urandom_range(10, 40);
        end
    end

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bilinear_resize_q11 test failed");
            $finish;
        end
    end

    // Offer one item and hold it until accepted. Sample tready mid-cycle,
    // where it is settled, and advance on the next edge.
    task automatic send(input kind_t kind, input int col, input int row, input int pix);
        int   gap;
        logic taken;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= (kind == KIND_PIXEL);
        s_tdata  <= {8'(pix), 8'(row), 8'(col)};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        if (kind == KIND_WRITE)
            written[row * 256 + col] = 1'b1;
    endtask

    // Drain the pipeline before touching registers; writes land late, so pad.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
        logic need_c [256];
        logic need_r [256];
        int   p;
        settle();
        cfg_we <= 1'b1; cfg_addr <= REG_SRC_WIDTH;  cfg_wdata <= SIZE_W'(sw); @(posedge clk);
        cfg_addr <= REG_SRC_HEIGHT; cfg_wdata <= SIZE_W'(sh); @(posedge clk);
        cfg_addr <= REG_DST_WIDTH;  cfg_wdata <= SIZE_W'(dw); @(posedge clk);
        cfg_addr <= REG_DST_HEIGHT; cfg_wdata <= SIZE_W'(dh); @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = (sw > 256) ? 256 : sw;
        cur_h = (sh > 256) ? 256 : sh;
        for (int i = 0; i < 256; i++)
        begin
            need_c[i] = 1'b0;
            need_r[i] = 1'b0;
        end
        // mark every source column and row that some request coordinate reads
        if (cur_w >= 2 && cur_h >= 2 && dw > 0 && dh > 0)
        begin
            for (int o = 0; o < 256; o++)
            begin
                p = src_pos(o, cur_w, dw);
                need_c[p]     = 1'b1;
                need_c[p + 1] = 1'b1;
                p = src_pos(o, cur_h, dh);
                need_r[p]     = 1'b1;
                need_r[p + 1] = 1'b1;
            end
        end
        // fill those cells that are still empty
        for (int r = 0; r < cur_h; r++)
            for (int c = 0; c < cur_w; c++)
                if (need_r[r] && need_c[c] && !written[r * 256 + c])
                    send(KIND_WRITE, c, r, $urandom_range(0, 255));
    endtask

    // Random mix: mostly requests, some writes inside the source area.
    task automatic random_items(input int count, input int dw, input int dh);
        for (int i = 0; i < count; i++)
        begin
            if (cur_w >= 2 && cur_h >= 2 && $urandom_range(0, 99) < 25)
                send(KIND_WRITE, $urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                     $urandom_range(0, 255));
            else if ($urandom_range(0, 99) < 75 && dw > 0 && dh > 0)
                send(KIND_PIXEL, $urandom_range(0, (dw > 256 ? 256 : dw) - 1),
                     $urandom_range(0, (dh > 256 ? 256 : dh) - 1), $urandom_range(0, 255));
            else
                send(KIND_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        int sw;
        int sh;
        int dw;
        int dh;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_SRC_WIDTH;
        cfg_wdata    = '0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        cycles       = 0;
        for (int i = 0; i < 65536; i++)
            written[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small image upscaled, corners, edges and far-out coordinates.
        set_sizes(4, 3, 7, 5);
        send(KIND_WRITE, 0, 0, 255);
        send(KIND_WRITE, 3, 2, 0);
        send(KIND_PIXEL, 0, 0, 0);       // left column and top row clamp
        send(KIND_PIXEL, 6, 4, 255);     // right edge and bottom row
        send(KIND_PIXEL, 3, 2, 0);
        send(KIND_PIXEL, 255, 255, 0);   // far outside the output
        send(KIND_PIXEL, 255, 0, 0);
        send(KIND_PIXEL, 0, 255, 0);

        // Wide and flat source, single output column.
        set_sizes(256, 2, 1, 256);
        send(KIND_PIXEL, 0, 0, 0);
        send(KIND_PIXEL, 0, 255, 0);
        random_items(20, 1, 256);

        // Narrow and tall source, single output row.
        set_sizes(2, 256, 256, 1);
        send(KIND_PIXEL, 255, 0, 0);
        send(KIND_PIXEL, 128, 200, 0);
        random_items(20, 256, 1);

        // Sizes above the store act as the store size; full register range.
        set_sizes(511, 2, 3, 511);
        random_items(15, 3, 511);
        set_sizes(2, 511, 3, 2);
        random_items(15, 3, 2);

        // Degenerate sizes answer zero.
        set_sizes(1, 5, 3, 4);
        send(KIND_PIXEL, 1, 1, 0);
        set_sizes(5, 0, 3, 4);
        send(KIND_PIXEL, 2, 2, 0);
        set_sizes(5, 5, 0, 4);
        send(KIND_PIXEL, 0, 3, 0);
        set_sizes(5, 5, 3, 0);
        send(KIND_PIXEL, 4, 0, 0);

        // Back to back with one long receiver hold-off: the block fills and stalls.
        set_sizes(9, 7, 20, 13);
        no_gaps      <= 1'b1;
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        random_items(90, 20, 13);
        no_gaps <= 1'b0;

        // Random sizes: down- and upscaling of small images.
        for (int p = 0; p < 8; p++)
        begin
            sw = $urandom_range(2, 12);
            sh = $urandom_range(2, 12);
            dw = $urandom_range(1, 40);
            dh = $urandom_range(1, 40);
            set_sizes(sw, sh, dw, dh);
            no_gaps <= (p % 3 == 2);
            random_items(25, dw, dh);
            no_gaps <= 1'b0;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("bilinear_resize_q11 test passed");
        else
            $display("bilinear_resize_q11 test failed");
        $finish;
    end

endmodule
